/* src/be3x3_pkg.sv */
package be3x3_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_ELEMENT_MASK = 2'd2
	} cfg_reg_t;

	// Field widths fixed by the register map.
	localparam int unsigned SIZE_W = 11;
	localparam int unsigned MASK_W = 9;
	localparam int unsigned CFG_DATA_W = 11;

	// Register values after reset; the mask is a cross.
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd7;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd7;
	localparam logic [MASK_W-1:0] MASK_RESET   = 9'd186;

	// Smallest legal image dimension.
	localparam int unsigned MIN_SIZE = 3;

	// The window shifts right by one column each item; these bits keep the
	// two older columns of every row.
	localparam logic [MASK_W-1:0] WIN_KEEP = 9'h0DB;

	// The centre pixel is always part of the structuring element.
	localparam logic [MASK_W-1:0] CENTER_BIT = 9'h010;

	// Window bit positions of the newest column, top to bottom row.
	localparam int unsigned TOP_POS = 2;
	localparam int unsigned MID_POS = 5;
	localparam int unsigned BOT_POS = 8;

endpackage

/* src/binary_erosion_3x3.sv */
// Pipeline: an accepted item passes the line store read in stage one, then the window
// and result register; items wait while the output side stalls.
// Throughput: one item per cycle while the output side does not stall; set by the single
// line store that is read and written once per item.
// Reset clears the position counters, the window and the pipeline valid flags, and loads
// the configuration registers with their defaults; the line stores are not cleared.
module binary_erosion_3x3 #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port
	input  logic                                cfg_write,
	input  logic [1:0]                          cfg_index,
	input  logic [be3x3_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Pixel input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                pixel_bit,
	input  logic                                frame_start,
	// Result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                eroded_bit,
	output logic                                result_valid,
	output logic                                frame_done
);

	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned SW0 = $clog2(MAX_WIDTH + 1) + 1;
	localparam int unsigned SH0 = $clog2(MAX_HEIGHT + 1) + 1;
	localparam int unsigned SW = (SW0 > be3x3_pkg::SIZE_W) ? SW0 : be3x3_pkg::SIZE_W;
	localparam int unsigned SH = (SH0 > be3x3_pkg::SIZE_W) ? SH0 : be3x3_pkg::SIZE_W;

	typedef logic [be3x3_pkg::MASK_W-1:0] win_t;

	// Item held between the line store read and the window.
	typedef struct packed {
		logic          pix;
		logic [CW-1:0] col;
		logic [RW-1:0] row;
	} stage_t;

	// Configuration registers.
	logic [be3x3_pkg::SIZE_W-1:0] image_width_q;
	logic [be3x3_pkg::SIZE_W-1:0] image_height_q;
	logic [be3x3_pkg::MASK_W-1:0] element_mask_q;

	// Position counters and window.
	logic [CW-1:0] column_count_q;
	logic [RW-1:0] row_count_q;
	win_t          window_q;

	// Stage one.
	logic   valid_s1;
	stage_t item_s1;
	logic [1:0] rd_s1;

	// Output register.
	logic out_valid_q;
	logic eroded_q;
	logic result_valid_q;
	logic frame_done_q;

	// Line store: bit 1 is the row two above, bit 0 the row just above.
	logic [1:0] line_mem [MAX_WIDTH];

	logic [SW-1:0] w_cl;
	logic [SH-1:0] h_cl;
	logic [SW-1:0] c_cur;
	logic [SH-1:0] r_cur;
	logic [SW-1:0] c_nxt;
	logic [SH-1:0] r_nxt;
	logic          in_acc;
	logic          adv_s1;
	logic          fwd;
	win_t          win_nxt;
	win_t          need;
	logic          res_valid;
	logic          res_eroded;
	logic          res_done;
	logic [SW-1:0] c_s1_ext;
	logic [SH-1:0] r_s1_ext;

	// Handshake: stage one moves on whenever the output register is free or emptying.
	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign eroded_bit   = eroded_q;
	assign result_valid = result_valid_q;
	assign frame_done   = frame_done_q;

	// Image size clamped to the legal range.
	always_comb begin
		if (SW'(image_width_q) < SW'(be3x3_pkg::MIN_SIZE)) begin
			w_cl = SW'(be3x3_pkg::MIN_SIZE);
		end else if (SW'(image_width_q) > SW'(MAX_WIDTH)) begin
			w_cl = SW'(MAX_WIDTH);
		end else begin
			w_cl = SW'(image_width_q);
		end
		if (SH'(image_height_q) < SH'(be3x3_pkg::MIN_SIZE)) begin
			h_cl = SH'(be3x3_pkg::MIN_SIZE);
		end else if (SH'(image_height_q) > SH'(MAX_HEIGHT)) begin
			h_cl = SH'(MAX_HEIGHT);
		end else begin
			h_cl = SH'(image_height_q);
		end
	end

	// Position of the incoming item and the position after it.
	always_comb begin
		if (frame_start) begin
			c_cur = '0;
			r_cur = '0;
		end else begin
			c_cur = SW'(column_count_q);
			r_cur = SH'(row_count_q);
			if (c_cur >= w_cl) begin
				c_cur = '0;
				r_cur = r_cur + SH'(1);
			end
			if (r_cur >= h_cl) begin
				r_cur = '0;
			end
		end
		c_nxt = c_cur + SW'(1);
		r_nxt = r_cur;
		if (c_nxt >= w_cl) begin
			c_nxt = '0;
			r_nxt = r_cur + SH'(1);
			if (r_nxt >= h_cl) begin
				r_nxt = '0;
			end
		end
	end

	// Same column as the item now writing back: take its data directly.
	assign fwd = adv_s1 && (item_s1.col == c_cur[CW-1:0]);

	// Window update and result for the item in stage one.
	always_comb begin
		c_s1_ext = SW'(item_s1.col);
		r_s1_ext = SH'(item_s1.row);
		win_nxt = (window_q >> 1) & be3x3_pkg::WIN_KEEP;
		win_nxt[be3x3_pkg::TOP_POS] = rd_s1[1];
		win_nxt[be3x3_pkg::MID_POS] = rd_s1[0];
		win_nxt[be3x3_pkg::BOT_POS] = item_s1.pix;
		need = element_mask_q | be3x3_pkg::CENTER_BIT;
		res_valid = (r_s1_ext >= SH'(2)) || ((r_s1_ext == SH'(1)) && (c_s1_ext >= SW'(1)));
		// Interior centre pixels need two full rows and two full columns behind them.
		res_eroded = (r_s1_ext >= SH'(2)) && (c_s1_ext >= SW'(2)) &&
			((win_nxt & need) == need);
		res_done = (r_s1_ext == h_cl - SH'(1)) && (c_s1_ext == w_cl - SW'(1));
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= be3x3_pkg::WIDTH_RESET;
			image_height_q <= be3x3_pkg::HEIGHT_RESET;
			element_mask_q <= be3x3_pkg::MASK_RESET;
		end else if (cfg_write) begin
			unique case (be3x3_pkg::cfg_reg_t'(cfg_index))
				be3x3_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[be3x3_pkg::SIZE_W-1:0];
				end
				be3x3_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[be3x3_pkg::SIZE_W-1:0];
				end
				be3x3_pkg::REG_ELEMENT_MASK: begin
					element_mask_q <= cfg_data[be3x3_pkg::MASK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Position counters and stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
			valid_s1       <= 1'b0;
		end else begin
			if (in_acc) begin
				column_count_q <= c_nxt[CW-1:0];
				row_count_q    <= r_nxt[RW-1:0];
				valid_s1       <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.pix <= pixel_bit;
			item_s1.col <= c_cur[CW-1:0];
			item_s1.row <= r_cur[RW-1:0];
		end
	end

	// Line store: read on accept, write back when the item leaves stage one.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			line_mem[item_s1.col] <= {rd_s1[0], item_s1.pix};
		end
		if (in_acc) begin
			if (fwd) begin
				rd_s1 <= {rd_s1[0], item_s1.pix};
			end else begin
				rd_s1 <= line_mem[c_cur[CW-1:0]];
			end
		end
	end

	// Window and output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				window_q    <= win_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			eroded_q       <= res_eroded;
			result_valid_q <= res_valid;
			frame_done_q   <= res_done;
		end
	end

	// A pixel can only be eroded to one inside a valid result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && eroded_bit |-> result_valid)
		else $error("eroded bit set on a result that is not valid");

	// The last pixel of a frame always lies in the valid part of the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> result_valid)
		else $error("frame end reported on a result that is not valid");

	// A frame start puts the item at row zero, column zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && frame_start |=>
		valid_s1 && (item_s1.col == '0) && (item_s1.row == '0))
		else $error("frame start did not restart the position");

	// Stage one only holds back the input while the output is full and stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	// An item taken into stage one reaches the output register at the next edge
	// when the output side is not stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (!out_valid || out_ready) |=> out_valid)
		else $error("item lost between stage one and the output register");

endmodule
